FILE: sv/srws_pkg.sv
`default_nettype none

package srws_pkg;

    localparam int WINDOW_SIZE_DEF = 16;
    localparam int MAX_RESULTS     = 16;
    localparam int RES_W           = $clog2(MAX_RESULTS + 1);

    localparam logic [RES_W-1:0] RES_LAST = RES_W'(MAX_RESULTS - 1);
    localparam logic [RES_W-1:0] RES_FULL = RES_W'(MAX_RESULTS);

    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_PUMP  = 2'd1;
    localparam logic [1:0] FUNC_ACK   = 2'd2;
    localparam logic [1:0] FUNC_TICK  = 2'd3;

    localparam logic [1:0] ACT_NEW      = 2'd0;
    localparam logic [1:0] ACT_RESEND   = 2'd1;
    localparam logic [1:0] ACT_COMPLETE = 2'd2;
    localparam logic [1:0] ACT_STATUS   = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] ack_seq;
    } t_in_item;

    typedef struct packed {
        logic [15:0] seq;
        logic [1:0]  action;
        logic [15:0] base_now;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic       start_clr;
        logic       scan_clr;
        logic       ack_mark;
        logic       slide;
        logic       pump_emit;
        logic       tick_adv;
        logic       tick_emit;
        logic       fin_emit;
        logic [1:0] fin_action;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic ack_in_range;
        logic pump_can;
        logic pump_last;
        logic slide_ok;
        logic base_done;
        logic tick_busy;
        logic tick_hit;
        logic tick_last;
    } t_stat;

endpackage

`default_nettype wire

FILE: sv/srws_datapath.sv
`default_nettype none

module srws_datapath #(
    parameter int WINDOW_SIZE = srws_pkg::WINDOW_SIZE_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [15:0]        i_cfg_wdata,
    input  wire srws_pkg::t_in_item i_in,
    input  wire srws_pkg::t_cmd     i_cmd,
    input  wire logic               i_out_stall,
    output srws_pkg::t_stat         o_stat,
    output logic                    o_out_valid,
    output srws_pkg::t_out_item     o_out
);

    localparam int OFF_W = $clog2(WINDOW_SIZE + 1);

    logic [15:0]                   r_total;
    logic [15:0]                   r_base;
    logic [15:0]                   r_next;
    logic [WINDOW_SIZE-1:0]        r_bits;
    logic [OFF_W-1:0]              r_off;
    logic [srws_pkg::RES_W-1:0]    r_n;
    logic                          r_out_valid;
    srws_pkg::t_out_item           r_out;

    logic [16:0]            lim;
    logic [16:0]            next_p1;
    logic [15:0]            cnt;
    logic [15:0]            ack_off;
    logic [WINDOW_SIZE-1:0] range_mask;
    logic [WINDOW_SIZE-1:0] ack_set;
    logic [WINDOW_SIZE-1:0] rem;
    logic [WINDOW_SIZE-1:0] bits_sh;
    logic                   out_free;

    always_comb begin
        lim     = {1'b0, r_base} + 17'(WINDOW_SIZE);
        next_p1 = {1'b0, r_next} + 17'd1;
        cnt     = r_next - r_base;
        ack_off = i_in.ack_seq - r_base;
        for (int i = 0; i < WINDOW_SIZE; i++) begin
            range_mask[i] = (16'(i) < cnt);
            ack_set[i]    = (ack_off == 16'(i));
        end
        rem      = (~r_bits & range_mask) >> r_off;
        bits_sh  = r_bits >> r_off;
        out_free = !r_out_valid || !i_out_stall;

        o_stat.out_free     = out_free;
        o_stat.ack_in_range = (i_in.ack_seq >= r_base) && (i_in.ack_seq < r_next);
        o_stat.pump_can     = (r_n < srws_pkg::RES_FULL) && ({1'b0, r_next} < lim)
                              && (r_next < r_total);
        o_stat.pump_last    = (r_n == srws_pkg::RES_LAST) || (next_p1 >= lim)
                              || (next_p1 >= {1'b0, r_total});
        o_stat.slide_ok     = r_bits[0] && (r_base < r_next);
        o_stat.base_done    = (r_base >= r_total);
        o_stat.tick_busy    = (16'(r_off) < cnt) && (r_n < srws_pkg::RES_FULL);
        o_stat.tick_hit     = !bits_sh[0];
        o_stat.tick_last    = (r_n == srws_pkg::RES_LAST) || !(|(rem >> 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= 16'd1;
            r_base      <= '0;
            r_next      <= '0;
            r_bits      <= '0;
            r_off       <= '0;
            r_n         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_total <= i_cfg_wdata;
            end
            if (i_cmd.start_clr) begin
                r_base <= '0;
                r_next <= '0;
                r_bits <= '0;
            end
            if (i_cmd.scan_clr) begin
                r_off <= '0;
                r_n   <= '0;
            end
            if (i_cmd.ack_mark) begin
                r_bits <= r_bits | ack_set;
            end
            if (i_cmd.slide) begin
                r_bits <= r_bits >> 1;
                r_base <= r_base + 16'd1;
            end
            if (i_cmd.pump_emit) begin
                r_next <= r_next + 16'd1;
                r_n    <= r_n + 1'b1;
            end
            if (i_cmd.tick_emit) begin
                r_n <= r_n + 1'b1;
            end
            if (i_cmd.tick_adv || i_cmd.tick_emit) begin
                r_off <= r_off + 1'b1;
            end
            if (i_cmd.pump_emit || i_cmd.tick_emit || i_cmd.fin_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pump_emit) begin
            r_out.seq      <= r_next;
            r_out.action   <= srws_pkg::ACT_NEW;
            r_out.base_now <= r_base;
            r_out.last     <= o_stat.pump_last;
        end else if (i_cmd.tick_emit) begin
            r_out.seq      <= r_base + 16'(r_off);
            r_out.action   <= srws_pkg::ACT_RESEND;
            r_out.base_now <= r_base;
            r_out.last     <= o_stat.tick_last;
        end else if (i_cmd.fin_emit) begin
            r_out.seq      <= '0;
            r_out.action   <= i_cmd.fin_action;
            r_out.base_now <= r_base;
            r_out.last     <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

FILE: sv/srws_ctrl.sv
`default_nettype none

module srws_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire srws_pkg::t_in_item i_in,
    input  wire srws_pkg::t_stat    i_stat,
    output logic                    o_in_stall,
    output srws_pkg::t_cmd          o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUMP,
        S_SLIDE,
        S_TICK,
        S_FINAL
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_fin_act, n_fin_act;

    always_comb begin
        n_state   = r_state;
        n_fin_act = r_fin_act;
        o_cmd     = '0;
        o_cmd.fin_action = r_fin_act;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_in.func)
                        srws_pkg::FUNC_START: begin
                            o_cmd.start_clr = 1'b1;
                            n_fin_act       = srws_pkg::ACT_STATUS;
                            n_state         = S_FINAL;
                        end
                        srws_pkg::FUNC_PUMP: begin
                            o_cmd.scan_clr = 1'b1;
                            n_state        = S_PUMP;
                        end
                        srws_pkg::FUNC_ACK: begin
                            n_fin_act = srws_pkg::ACT_STATUS;
                            if (i_stat.ack_in_range) begin
                                o_cmd.ack_mark = 1'b1;
                                n_state        = S_SLIDE;
                            end else begin
                                n_state = S_FINAL;
                            end
                        end
                        default: begin
                            o_cmd.scan_clr = 1'b1;
                            n_state        = S_TICK;
                        end
                    endcase
                end
            end
            S_PUMP: begin
                if (!i_stat.pump_can) begin
                    n_fin_act = srws_pkg::ACT_STATUS;
                    n_state   = S_FINAL;
                end else if (i_stat.out_free) begin
                    o_cmd.pump_emit = 1'b1;
                    if (i_stat.pump_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SLIDE: begin
                if (i_stat.slide_ok) begin
                    o_cmd.slide = 1'b1;
                end else begin
                    n_fin_act = i_stat.base_done ? srws_pkg::ACT_COMPLETE
                                                 : srws_pkg::ACT_STATUS;
                    n_state   = S_FINAL;
                end
            end
            S_TICK: begin
                if (!i_stat.tick_busy) begin
                    n_fin_act = srws_pkg::ACT_STATUS;
                    n_state   = S_FINAL;
                end else if (!i_stat.tick_hit) begin
                    o_cmd.tick_adv = 1'b1;
                end else if (i_stat.out_free) begin
                    o_cmd.tick_emit = 1'b1;
                    if (i_stat.tick_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_FINAL: begin
                if (i_stat.out_free) begin
                    o_cmd.fin_emit = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_fin_act <= srws_pkg::ACT_STATUS;
        end else begin
            r_state   <= n_state;
            r_fin_act <= n_fin_act;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

FILE: sv/selective_repeat_window_sender.sv
// An accepted item moves the controller out of idle; its results are loaded into the
// output register. An in-range ack marks its bit, then slides; a tick skips acknowledged numbers.
// One item at a time; pump and tick walk the window one sequence number per cycle,
// and an ack slides the base one per cycle.
// A stalled result holds the walk. The next item is taken the cycle after the last result is loaded.
// Reset (synchronous, active low): empty window, base and next at 0, total 1.
`default_nettype none

module selective_repeat_window_sender #(
    parameter int WINDOW_SIZE = srws_pkg::WINDOW_SIZE_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [15:0]         i_cfg_wdata,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire srws_pkg::t_in_item  i_in,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output srws_pkg::t_out_item      o_out
);

    srws_pkg::t_cmd  cmd;
    srws_pkg::t_stat stat;

    srws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    srws_datapath #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

FILE: sv/srws_checker.sv
`default_nettype none

module srws_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_cfg_we,
    input wire logic [15:0]         i_cfg_wdata,
    input wire logic                i_in_valid,
    input wire logic                o_in_stall,
    input wire srws_pkg::t_in_item  i_in,
    input wire logic                o_out_valid,
    input wire logic                i_out_stall,
    input wire srws_pkg::t_out_item o_out
);

    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("item accepted while previous item in flight");

    a_final_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.action == srws_pkg::ACT_COMPLETE
                        || o_out.action == srws_pkg::ACT_STATUS)
        |-> o_out.last && (o_out.seq == 16'd0))
        else $error("status or complete result not final or nonzero seq");

endmodule

bind selective_repeat_window_sender srws_checker u_srws_checker (.*);

`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int WIN   = srws_pkg::WINDOW_SIZE_DEF;
    localparam int WIN_W = (WIN > 1) ? $clog2(WIN) : 1;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [15:0]         cfg_wdata;
    logic                in_valid;
    logic                in_stall;
    srws_pkg::t_in_item  in_item;
    logic                out_valid;
    logic                out_stall;
    srws_pkg::t_out_item out_item;

    selective_repeat_window_sender #(
        .WINDOW_SIZE(WIN)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in       (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out      (out_item)
    );

    logic [15:0]    win_base;
    logic [15:0]    nxt_seq;
    logic [15:0]    total_cnt;
    logic [WIN-1:0] acked;

    srws_pkg::t_out_item pending_results[$];
    int                  err_count;
    int                  send_idle_pct;
    int                  recv_idle_pct;
    int                  hold_cycles;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (err_count < 40) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
        err_count++;
    endtask

    function automatic srws_pkg::t_out_item window_result(input logic [15:0] seq,
                                                          input logic [1:0]  act);
        srws_pkg::t_out_item r;
        r.seq      = seq;
        r.action   = act;
        r.base_now = win_base;
        r.last     = 1'b0;
        return r;
    endfunction

    // advance the window copy by one item and queue what it emits
    task automatic window_step(input srws_pkg::t_in_item it);
        srws_pkg::t_out_item res[$];
        int unsigned         off;
        int unsigned         s;
        case (it.func)
            srws_pkg::FUNC_START: begin
                win_base = '0;
                nxt_seq  = '0;
                acked    = '0;
            end
            srws_pkg::FUNC_PUMP: begin
                while (res.size() < srws_pkg::MAX_RESULTS &&
                       int'(nxt_seq) < int'(win_base) + WIN &&
                       nxt_seq < total_cnt) begin
                    res.push_back(window_result(nxt_seq, srws_pkg::ACT_NEW));
                    nxt_seq = nxt_seq + 16'd1;
                end
            end
            srws_pkg::FUNC_ACK: begin
                if (it.ack_seq >= win_base && it.ack_seq < nxt_seq) begin
                    off = it.ack_seq - win_base;
                    if (off < WIN) begin
                        acked[off[WIN_W-1:0]] = 1'b1;
                    end
                    while (acked[0] && win_base < nxt_seq) begin
                        acked    = acked >> 1;
                        win_base = win_base + 16'd1;
                    end
                    if (win_base >= total_cnt) begin
                        res.push_back(window_result('0, srws_pkg::ACT_COMPLETE));
                    end
                end
            end
            default: begin
                for (s = win_base; s < nxt_seq && res.size() < srws_pkg::MAX_RESULTS; s++) begin
                    off = s - win_base;
                    if (off >= WIN) begin
                        break;
                    end
                    if (!acked[off[WIN_W-1:0]]) begin
                        res.push_back(window_result(16'(s), srws_pkg::ACT_RESEND));
                    end
                end
            end
        endcase
        if (res.size() == 0) begin
            res.push_back(window_result('0, srws_pkg::ACT_STATUS));
        end
        res[res.size()-1].last = 1'b1;
        foreach (res[i]) begin
            pending_results.push_back(res[i]);
        end
    endtask

    task automatic send_item(input logic [1:0] func, input logic [15:0] ack_seq);
        srws_pkg::t_in_item it;
        it.func    = func;
        it.ack_seq = ack_seq;
        window_step(it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_total(input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        total_cnt = value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [15:0] pick_outstanding();
        int unsigned span;
        span = nxt_seq - win_base;
        if (span == 0 || $urandom_range(0, 1)) begin
            return win_base;
        end
        return win_base + 16'($urandom_range(0, span - 1));
    endfunction

    task automatic test_directed();
        send_item(srws_pkg::FUNC_PUMP, 16'd0);
        send_item(srws_pkg::FUNC_TICK, 16'd0);
        send_item(srws_pkg::FUNC_ACK, 16'd0);
        send_item(srws_pkg::FUNC_PUMP, 16'd0);
        wait_idle();
        write_total(16'hFFFF);
        send_item(srws_pkg::FUNC_START, 16'hFFFF);
        send_item(srws_pkg::FUNC_PUMP, 16'd0);
        send_item(srws_pkg::FUNC_PUMP, 16'd0);
        send_item(srws_pkg::FUNC_TICK, 16'd0);
        send_item(srws_pkg::FUNC_ACK, 16'd5);
        send_item(srws_pkg::FUNC_ACK, 16'd0);
        send_item(srws_pkg::FUNC_ACK, 16'hFFFF);
        send_item(srws_pkg::FUNC_ACK, 16'd16);
        send_item(srws_pkg::FUNC_TICK, 16'd0);
        send_item(srws_pkg::FUNC_PUMP, 16'd0);
        // shrink the transfer below next, then to zero
        wait_idle();
        write_total(16'd3);
        send_item(srws_pkg::FUNC_PUMP, 16'd0);
        send_item(srws_pkg::FUNC_ACK, 16'd1);
        wait_idle();
        write_total(16'd0);
        send_item(srws_pkg::FUNC_ACK, 16'd2);
        send_item(srws_pkg::FUNC_START, 16'd0);
        send_item(srws_pkg::FUNC_TICK, 16'd0);
        send_item(srws_pkg::FUNC_ACK, 16'd0);
        wait_idle();
    endtask

    task automatic test_random_transfers(input int n_items);
        int count;
        int budget;
        int roll;
        count = 0;
        while (count < n_items) begin
            wait_idle();
            if ($urandom_range(0, 9) == 0) begin
                write_total(16'($urandom_range(41, 65535)));
            end else begin
                write_total(16'($urandom_range(1, 40)));
            end
            send_item(srws_pkg::FUNC_START, 16'($urandom));
            count++;
            budget = $urandom_range(30, 120);
            while (budget > 0 && count < n_items) begin
                roll = $urandom_range(0, 99);
                if (roll < 35 || (roll < 80 && nxt_seq == win_base)) begin
                    send_item(srws_pkg::FUNC_PUMP, 16'($urandom));
                end else if (roll < 80) begin
                    send_item(srws_pkg::FUNC_ACK, pick_outstanding());
                end else if (roll < 89) begin
                    send_item(srws_pkg::FUNC_TICK, 16'($urandom));
                end else if (roll < 95) begin
                    send_item(srws_pkg::FUNC_ACK, 16'($urandom));
                end else if (roll < 97) begin
                    send_item(srws_pkg::FUNC_ACK,
                              $urandom_range(0, 1) ? win_base - 16'd1 : nxt_seq);
                end else if (roll < 98) begin
                    send_item(srws_pkg::FUNC_START, 16'($urandom));
                end else begin
                    wait_idle();
                    write_total(16'($urandom_range(0, int'(nxt_seq) + 5)));
                    send_item(srws_pkg::FUNC_PUMP, 16'($urandom));
                end
                count++;
                budget--;
                if (nxt_seq != 0 && win_base >= total_cnt) begin
                    break;
                end
            end
        end
        wait_idle();
    endtask

    task automatic test_backpressure();
        int saved_send;
        saved_send    = send_idle_pct;
        send_idle_pct = 0;
        write_total(16'd100);
        send_item(srws_pkg::FUNC_START, 16'd0);
        send_item(srws_pkg::FUNC_PUMP, 16'd0);
        hold_cycles = 400;
        repeat (15) begin
            send_item(srws_pkg::FUNC_TICK, 16'd0);
            send_item(srws_pkg::FUNC_ACK, pick_outstanding());
        end
        send_idle_pct = saved_send;
        wait_idle();
    endtask

    // drive receiver stall; hold it for a long stretch when asked
    always @(negedge clk) begin
        if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge clk) begin : check_p
        srws_pkg::t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected item seq=%0d action=%0d base=%0d last=%0d",
                                          out_item.seq, out_item.action, out_item.base_now,
                                          out_item.last));
            end else begin
                want = pending_results.pop_front();
                if (out_item.seq !== want.seq || out_item.action !== want.action ||
                    out_item.base_now !== want.base_now || out_item.last !== want.last) begin
                    report_mismatch($sformatf(
                        "got seq=%0d action=%0d base=%0d last=%0d, want %0d %0d %0d %0d",
                        out_item.seq, out_item.action, out_item.base_now, out_item.last,
                        want.seq, want.action, want.base_now, want.last));
                end
            end
        end
    end

    initial begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        in_valid      = 1'b0;
        in_item       = '0;
        out_stall     = 1'b0;
        err_count     = 0;
        hold_cycles   = 0;
        send_idle_pct = 30;
        recv_idle_pct = 59;
        win_base      = '0;
        nxt_seq       = '0;
        acked         = '0;
        total_cnt     = 16'd1;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_random_transfers(150);

        send_idle_pct = 59;
        recv_idle_pct = 30;
        test_random_transfers(150);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random_transfers(120);

        wait_idle();
        repeat (20) @(negedge clk);
        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
